@@ rtl/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, register indexes and types for the triangle pixel shader.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int COORD_INT_BITS   = 12;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int PIX_W      = 12;
    localparam int COORD_W    = 16;
    localparam int FRAC_BITS  = COORD_W - COORD_INT_BITS;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 4;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DSQ_W      = SQ_W + 1;
    localparam int SQRT_STEPS = 18;
    localparam int SQRT_W     = 2 * SQRT_STEPS;
    localparam int DIST_W     = COORD_W + 1;
    localparam int P_W        = 2 * DIST_W;
    localparam int S_W        = P_W + 2;
    localparam int REM_W      = S_W + 1;
    localparam int W_W        = WEIGHT_FRAC_BITS;
    localparam int CH_W       = 8;
    localparam int MUL_W      = W_W + CH_W;
    localparam int MAC_W      = MUL_W + 2;
    localparam int RGB_W      = 3 * CH_W;
    localparam int VTX_W      = 2 * COORD_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_VERTEX_A,
        REG_VERTEX_B,
        REG_VERTEX_C,
        REG_COLOR_A,
        REG_COLOR_B,
        REG_COLOR_C,
        REG_BACKGROUND
    } reg_index_t;

    localparam logic [VTX_W-1:0] VERTEX_A_RST   = 32'd262146000;
    localparam logic [VTX_W-1:0] VERTEX_B_RST   = 32'd786434000;
    localparam logic [VTX_W-1:0] VERTEX_C_RST   = 32'd524294000;
    localparam logic [RGB_W-1:0] COLOR_A_RST    = 24'hFF0000;
    localparam logic [RGB_W-1:0] COLOR_B_RST    = 24'h00FF00;
    localparam logic [RGB_W-1:0] COLOR_C_RST    = 24'h0000FF;
    localparam logic [RGB_W-1:0] BACKGROUND_RST = 24'h334C4C;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [VTX_W-1:0] vertex_c;
        logic [RGB_W-1:0] color_a;
        logic [RGB_W-1:0] color_b;
        logic [RGB_W-1:0] color_c;
        logic [RGB_W-1:0] background;
    } cfg_t;

    typedef struct packed {
        logic vld;
        logic hit;
    } ctl_t;

endpackage

@@ rtl/tps_edge.sv @@
// ----------------------------------------------------------------------------
// tps_edge
// Edge cross products, inside test and squared vertex distances, four stages.
// ----------------------------------------------------------------------------
module tps_edge (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  tps_pkg::cfg_t                          cfg,
    input  logic                                   in_vld,
    input  logic [tps_pkg::PIX_W-1:0]              pixel_x,
    input  logic [tps_pkg::PIX_W-1:0]              pixel_y,
    output tps_pkg::ctl_t                          ctl_out,
    output logic [2:0][tps_pkg::DSQ_W-1:0]         dsq_out
);
    import tps_pkg::*;

    function automatic logic signed [PROD_W-1:0] smul(input logic signed [DIFF_W-1:0] a,
                                                      input logic signed [DIFF_W-1:0] b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic logic signed [DIFF_W-1:0] u2s(input logic [COORD_W-1:0] v);
        return signed'({1'b0, v});
    endfunction

    // stage a: pixel in coordinate units
    logic                 a_vld_reg;
    logic [COORD_W-1:0]   px_reg, py_reg;
    logic [COORD_W-1:0]   px_next, py_next;

    assign px_next = COORD_W'(pixel_x) << FRAC_BITS;
    assign py_next = COORD_W'(pixel_y) << FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
        end
        if (en) begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // stage b: products
    logic signed [DIFF_W-1:0] x  [3];
    logic signed [DIFF_W-1:0] y  [3];
    logic signed [DIFF_W-1:0] ps, qs;
    logic signed [PROD_W-1:0] prod_next [12];
    logic signed [PROD_W-1:0] prod_reg  [12];
    logic [SQ_W-1:0]          sq_next   [3][2];
    logic [SQ_W-1:0]          sq_reg    [3][2];
    logic                     b_vld_reg;

    always_comb begin
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [PROD_W-1:0] t;
        x[0] = u2s(cfg.vertex_a[VTX_W-1:COORD_W]);
        y[0] = u2s(cfg.vertex_a[COORD_W-1:0]);
        x[1] = u2s(cfg.vertex_b[VTX_W-1:COORD_W]);
        y[1] = u2s(cfg.vertex_b[COORD_W-1:0]);
        x[2] = u2s(cfg.vertex_c[VTX_W-1:COORD_W]);
        y[2] = u2s(cfg.vertex_c[COORD_W-1:0]);
        ps   = u2s(px_reg);
        qs   = u2s(py_reg);
        prod_next[0]  = smul(y[0], x[2]);
        prod_next[1]  = smul(x[0], y[2]);
        prod_next[2]  = smul(DIFF_W'(y[2] - y[0]), ps);
        prod_next[3]  = smul(DIFF_W'(x[0] - x[2]), qs);
        prod_next[4]  = smul(x[0], y[1]);
        prod_next[5]  = smul(y[0], x[1]);
        prod_next[6]  = smul(DIFF_W'(y[0] - y[1]), ps);
        prod_next[7]  = smul(DIFF_W'(x[1] - x[0]), qs);
        prod_next[8]  = smul(y[1], x[2]);
        prod_next[9]  = smul(y[0], DIFF_W'(x[2] - x[1]));
        prod_next[10] = smul(x[0], DIFF_W'(y[1] - y[2]));
        prod_next[11] = smul(x[1], y[2]);
        for (int v = 0; v < 3; v++) begin
            dx = DIFF_W'(x[v] - ps);
            dy = DIFF_W'(y[v] - qs);
            t  = smul(dx, dx);
            sq_next[v][0] = t[SQ_W-1:0];
            t  = smul(dy, dy);
            sq_next[v][1] = t[SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
        if (en) begin
            prod_reg <= prod_next;
            sq_reg   <= sq_next;
        end
    end

    // stage c: sums
    logic signed [EDGE_W-1:0] sn_reg, tn_reg, a2_reg;
    logic signed [EDGE_W-1:0] sn_next, tn_next, a2_next;
    logic [DSQ_W-1:0]         dsq_c_reg  [3];
    logic [DSQ_W-1:0]         dsq_c_next [3];
    logic                     c_vld_reg;

    always_comb begin
        sn_next = EDGE_W'(prod_reg[0]) - EDGE_W'(prod_reg[1])
                + EDGE_W'(prod_reg[2]) + EDGE_W'(prod_reg[3]);
        tn_next = EDGE_W'(prod_reg[4]) - EDGE_W'(prod_reg[5])
                + EDGE_W'(prod_reg[6]) + EDGE_W'(prod_reg[7]);
        a2_next = EDGE_W'(prod_reg[9]) - EDGE_W'(prod_reg[8])
                + EDGE_W'(prod_reg[10]) + EDGE_W'(prod_reg[11]);
        for (int v = 0; v < 3; v++) begin
            dsq_c_next[v] = DSQ_W'(sq_reg[v][0]) + DSQ_W'(sq_reg[v][1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
        if (en) begin
            sn_reg    <= sn_next;
            tn_reg    <= tn_next;
            a2_reg    <= a2_next;
            dsq_c_reg <= dsq_c_next;
        end
    end

    // stage d: inside decision
    logic signed [EDGE_W-1:0] un;
    logic                     inside_next;
    logic                     d_vld_reg, inside_reg;
    logic [2:0][DSQ_W-1:0]    dsq_d_reg;

    always_comb begin
        un = a2_reg - sn_reg - tn_reg;
        if (a2_reg > 0) begin
            inside_next = (sn_reg > 0) && (tn_reg > 0) && (un > 0);
        end else if (a2_reg < 0) begin
            inside_next = (sn_reg < 0) && (tn_reg < 0) && (un < 0);
        end else begin
            inside_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= c_vld_reg;
        end
        if (en) begin
            inside_reg   <= inside_next;
            dsq_d_reg[0] <= dsq_c_reg[0];
            dsq_d_reg[1] <= dsq_c_reg[1];
            dsq_d_reg[2] <= dsq_c_reg[2];
        end
    end

    assign ctl_out.vld = d_vld_reg;
    assign ctl_out.hit = inside_reg;
    assign dsq_out     = dsq_d_reg;

endmodule

@@ rtl/tps_sqrt.sv @@
// ----------------------------------------------------------------------------
// tps_sqrt
// Three-lane integer square root, one bit pair per pipeline stage.
// ----------------------------------------------------------------------------
module tps_sqrt (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  tps_pkg::ctl_t                          ctl_in,
    input  logic [2:0][tps_pkg::DSQ_W-1:0]         dsq_in,
    output tps_pkg::ctl_t                          ctl_out,
    output logic [2:0][tps_pkg::DIST_W-1:0]        dist_out
);
    import tps_pkg::*;

    logic [SQRT_W-1:0] v_reg   [SQRT_STEPS][3];
    logic [SQRT_W-1:0] res_reg [SQRT_STEPS][3];
    ctl_t              ctl_reg [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * i);
        logic [SQRT_W-1:0] v_in    [3];
        logic [SQRT_W-1:0] res_in  [3];
        logic [SQRT_W-1:0] v_next  [3];
        logic [SQRT_W-1:0] res_next[3];
        ctl_t              ctl_in_s;

        if (i == 0) begin : g_first
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign v_in[l]   = SQRT_W'(dsq_in[l]);
                assign res_in[l] = '0;
            end
            assign ctl_in_s = ctl_in;
        end else begin : g_rest
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign v_in[l]   = v_reg[i-1][l];
                assign res_in[l] = res_reg[i-1][l];
            end
            assign ctl_in_s = ctl_reg[i-1];
        end

        always_comb begin
            logic [SQRT_W-1:0] trial;
            for (int l = 0; l < 3; l++) begin
                trial = res_in[l] + BIT;
                if (v_in[l] >= trial) begin
                    v_next[l]   = v_in[l] - trial;
                    res_next[l] = (res_in[l] >> 1) + BIT;
                end else begin
                    v_next[l]   = v_in[l];
                    res_next[l] = res_in[l] >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i].vld <= 1'b0;
            end else if (en) begin
                ctl_reg[i].vld <= ctl_in_s.vld;
            end
            if (en) begin
                ctl_reg[i].hit <= ctl_in_s.hit;
                for (int l = 0; l < 3; l++) begin
                    v_reg[i][l]   <= v_next[l];
                    res_reg[i][l] <= res_next[l];
                end
            end
        end
    end

    // zero distance counts as one
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (res_reg[SQRT_STEPS-1][l] == '0) begin
                dist_out[l] = DIST_W'(1);
            end else begin
                dist_out[l] = res_reg[SQRT_STEPS-1][l][DIST_W-1:0];
            end
        end
    end

    assign ctl_out = ctl_reg[SQRT_STEPS-1];

endmodule

@@ rtl/tps_weight.sv @@
// ----------------------------------------------------------------------------
// tps_weight
// Distance products and normalized weights by a pipelined restoring divider.
// ----------------------------------------------------------------------------
module tps_weight (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  tps_pkg::ctl_t                          ctl_in,
    input  logic [2:0][tps_pkg::DIST_W-1:0]        dist_in,
    output tps_pkg::ctl_t                          ctl_out,
    output logic [2:0][tps_pkg::W_W-1:0]           w_out
);
    import tps_pkg::*;

    // stage p: pairwise products
    logic [P_W-1:0] p_reg [3];
    ctl_t           p_ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctl_reg.vld <= 1'b0;
        end else if (en) begin
            p_ctl_reg.vld <= ctl_in.vld;
        end
        if (en) begin
            p_ctl_reg.hit <= ctl_in.hit;
            p_reg[0] <= P_W'(dist_in[1]) * P_W'(dist_in[2]);
            p_reg[1] <= P_W'(dist_in[0]) * P_W'(dist_in[2]);
            p_reg[2] <= P_W'(dist_in[0]) * P_W'(dist_in[1]);
        end
    end

    // stage s: denominator
    logic [P_W-1:0] ps_reg [3];
    logic [S_W-1:0] s_reg;
    ctl_t           s_ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_ctl_reg.vld <= 1'b0;
        end else if (en) begin
            s_ctl_reg.vld <= p_ctl_reg.vld;
        end
        if (en) begin
            s_ctl_reg.hit <= p_ctl_reg.hit;
            ps_reg <= p_reg;
            s_reg  <= S_W'(p_reg[0]) + S_W'(p_reg[1]) + S_W'(p_reg[2]);
        end
    end

    // divider stages, one quotient bit each
    logic [REM_W-1:0] rem_reg [W_W][3];
    logic [W_W-1:0]   q_reg   [W_W][3];
    logic [S_W-1:0]   sd_reg  [W_W];
    ctl_t             dctl_reg[W_W];

    for (genvar i = 0; i < W_W; i++) begin : g_div
        logic [REM_W-1:0] rem_in  [3];
        logic [W_W-1:0]   q_in    [3];
        logic [REM_W-1:0] rem_next[3];
        logic [W_W-1:0]   q_next  [3];
        logic [S_W-1:0]   sd_in;
        ctl_t             ctl_in_s;

        if (i == 0) begin : g_first
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = REM_W'(ps_reg[l]);
                assign q_in[l]   = '0;
            end
            assign sd_in    = s_reg;
            assign ctl_in_s = s_ctl_reg;
        end else begin : g_rest
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = rem_reg[i-1][l];
                assign q_in[l]   = q_reg[i-1][l];
            end
            assign sd_in    = sd_reg[i-1];
            assign ctl_in_s = dctl_reg[i-1];
        end

        always_comb begin
            logic [REM_W-1:0] sh;
            for (int l = 0; l < 3; l++) begin
                sh = rem_in[l] << 1;
                if (sh >= REM_W'(sd_in)) begin
                    rem_next[l] = sh - REM_W'(sd_in);
                    q_next[l]   = {q_in[l][W_W-2:0], 1'b1};
                end else begin
                    rem_next[l] = sh;
                    q_next[l]   = {q_in[l][W_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dctl_reg[i].vld <= 1'b0;
            end else if (en) begin
                dctl_reg[i].vld <= ctl_in_s.vld;
            end
            if (en) begin
                dctl_reg[i].hit <= ctl_in_s.hit;
                sd_reg[i]       <= sd_in;
                for (int l = 0; l < 3; l++) begin
                    rem_reg[i][l] <= rem_next[l];
                    q_reg[i][l]   <= q_next[l];
                end
            end
        end
    end

    assign ctl_out  = dctl_reg[W_W-1];
    assign w_out[0] = q_reg[W_W-1][0];
    assign w_out[1] = q_reg[W_W-1][1];
    assign w_out[2] = q_reg[W_W-1][2];

endmodule

@@ rtl/tps_blend.sv @@
// ----------------------------------------------------------------------------
// tps_blend
// Weighted color blend, saturation and background select, two stages.
// ----------------------------------------------------------------------------
module tps_blend (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  tps_pkg::cfg_t                          cfg,
    input  tps_pkg::ctl_t                          ctl_in,
    input  logic [2:0][tps_pkg::W_W-1:0]           w_in,
    output logic                                   out_vld,
    output logic [tps_pkg::RGB_W-1:0]              out_rgb,
    output logic                                   out_inside
);
    import tps_pkg::*;

    logic [RGB_W-1:0] color [3];
    logic [MUL_W-1:0] mul_reg  [3][3];
    logic [MUL_W-1:0] mul_next [3][3];
    ctl_t             m_ctl_reg;

    assign color[0] = cfg.color_a;
    assign color[1] = cfg.color_b;
    assign color[2] = cfg.color_c;

    // channel 0 is red, taken from the top byte
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int v = 0; v < 3; v++) begin
                mul_next[ch][v] = MUL_W'(w_in[v]) * MUL_W'(color[v][CH_W*(2-ch) +: CH_W]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_ctl_reg.vld <= 1'b0;
        end else if (en) begin
            m_ctl_reg.vld <= ctl_in.vld;
        end
        if (en) begin
            m_ctl_reg.hit <= ctl_in.hit;
            mul_reg       <= mul_next;
        end
    end

    logic [RGB_W-1:0] rgb_next;
    logic [RGB_W-1:0] rgb_reg;
    logic             vld_reg, inside_reg;

    always_comb begin
        logic [MAC_W-1:0] acc;
        logic [MAC_W-1:0] sh;
        for (int ch = 0; ch < 3; ch++) begin
            acc = MAC_W'(mul_reg[ch][0]) + MAC_W'(mul_reg[ch][1]) + MAC_W'(mul_reg[ch][2]);
            sh  = acc >> W_W;
            if (!m_ctl_reg.hit) begin
                rgb_next[CH_W*ch +: CH_W] = cfg.background[CH_W*(2-ch) +: CH_W];
            end else if (sh > MAC_W'(255)) begin
                rgb_next[CH_W*ch +: CH_W] = '1;
            end else begin
                rgb_next[CH_W*ch +: CH_W] = sh[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= m_ctl_reg.vld;
        end
        if (en) begin
            rgb_reg    <= rgb_next;
            inside_reg <= m_ctl_reg.hit;
        end
    end

    assign out_vld    = vld_reg;
    assign out_rgb    = rgb_reg;
    assign out_inside = inside_reg;

endmodule

@@ rtl/triangle_pixel_shader.sv @@
// ----------------------------------------------------------------------------
// triangle_pixel_shader
// Inside test against a configured triangle and inverse-distance color blend.
// ----------------------------------------------------------------------------
// pipeline: edge, sqrt, weight and blend stages
// throughput: one item per cycle; m_tready low while m_tvalid is high holds
//   the whole pipeline
// reset: synchronous, clears all valid bits and loads default registers
module triangle_pixel_shader (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // pixel_x, pixel_y
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // red, green, blue
    output logic                              m_tuser,  // inside_res
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tps_pkg::*;

    cfg_t cfg_reg;
    logic en;

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vertex_a   <= VERTEX_A_RST;
            cfg_reg.vertex_b   <= VERTEX_B_RST;
            cfg_reg.vertex_c   <= VERTEX_C_RST;
            cfg_reg.color_a    <= COLOR_A_RST;
            cfg_reg.color_b    <= COLOR_B_RST;
            cfg_reg.color_c    <= COLOR_C_RST;
            cfg_reg.background <= BACKGROUND_RST;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_VERTEX_A:   cfg_reg.vertex_a   <= cfg_data[VTX_W-1:0];
                REG_VERTEX_B:   cfg_reg.vertex_b   <= cfg_data[VTX_W-1:0];
                REG_VERTEX_C:   cfg_reg.vertex_c   <= cfg_data[VTX_W-1:0];
                REG_COLOR_A:    cfg_reg.color_a    <= cfg_data[RGB_W-1:0];
                REG_COLOR_B:    cfg_reg.color_b    <= cfg_data[RGB_W-1:0];
                REG_COLOR_C:    cfg_reg.color_c    <= cfg_data[RGB_W-1:0];
                REG_BACKGROUND: cfg_reg.background <= cfg_data[RGB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ctl_t                   edge_ctl, sqrt_ctl, wt_ctl;
    logic [2:0][DSQ_W-1:0]  dsq;
    logic [2:0][DIST_W-1:0] vdist;
    logic [2:0][W_W-1:0]    w;

    tps_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cfg     (cfg_reg),
        .in_vld  (s_tvalid),
        .pixel_x (s_tdata[PIX_W-1:0]),
        .pixel_y (s_tdata[2*PIX_W-1:PIX_W]),
        .ctl_out (edge_ctl),
        .dsq_out (dsq)
    );

    tps_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctl_in   (edge_ctl),
        .dsq_in   (dsq),
        .ctl_out  (sqrt_ctl),
        .dist_out (vdist)
    );

    tps_weight u_weight (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (sqrt_ctl),
        .dist_in (vdist),
        .ctl_out (wt_ctl),
        .w_out   (w)
    );

    tps_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cfg        (cfg_reg),
        .ctl_in     (wt_ctl),
        .w_in       (w),
        .out_vld    (m_tvalid),
        .out_rgb    (m_tdata),
        .out_inside (m_tuser)
    );

endmodule

@@ rtl/tps_checker.sv @@
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks on the shader's stall and reset behavior.
// ----------------------------------------------------------------------------
module tps_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [23:0]                       m_tdata,
    input logic                              m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side moves only when the output side can
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an outside item reports the same flag for the whole stall
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && !m_tuser |=> !m_tuser)
        else $error("inside flag changed while stalled");

endmodule

bind triangle_pixel_shader tps_checker u_tps_checker (.*);

@@ bench/tb_triangle_pixel_shader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_pixel_shader
// Streams pixel coordinates through the shader under several triangle and
// color settings and checks every shaded pixel against an exact predictor
// of the inside test and the inverse-distance color blend.
// ----------------------------------------------------------------------------
module tb_triangle_pixel_shader;
    import tps_pkg::*;

    localparam int LATENCY   = 42;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       hit;
    } pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [31:0] vtx_a, vtx_b, vtx_c;
    logic [23:0] col_a, col_b, col_c, col_bg;

    logic [23:0] pending_pixels[$];
    pixel_t      expected_pixels[$];
    int          errors;
    int          cycles;
    int          burst_left;
    int          gap_left;
    bit          hold_sender;

    triangle_pixel_shader u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 34;
        for (int i = 0; i < 18; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned vertex_dist(longint ax, longint ay,
                                                    longint px, longint py);
        longint dx, dy;
        longint unsigned d;
        dx = ax - px;
        dy = ay - py;
        d = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
        return (d == 0) ? 1 : d;
    endfunction

    function automatic logic [7:0] blend(longint unsigned w0, longint unsigned w1,
                                         longint unsigned w2, int sh);
        longint unsigned acc;
        acc = w0 * ((col_a >> sh) & 8'hFF) + w1 * ((col_b >> sh) & 8'hFF)
            + w2 * ((col_c >> sh) & 8'hFF);
        acc = acc >> WEIGHT_FRAC_BITS;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function automatic pixel_t shade_pixel(logic [23:0] pix);
        longint px, py, x0, y0, x1, y1, x2, y2, a2, sn, tn, un;
        longint unsigned d0, d1, d2, p0, p1, p2, sum, w0, w1, w2;
        bit in_tri;
        pixel_t r;
        px = longint'(pix[11:0]) << FRAC_BITS;
        py = longint'(pix[23:12]) << FRAC_BITS;
        x0 = vtx_a[31:16]; y0 = vtx_a[15:0];
        x1 = vtx_b[31:16]; y1 = vtx_b[15:0];
        x2 = vtx_c[31:16]; y2 = vtx_c[15:0];
        a2 = -y1 * x2 + y0 * (x2 - x1) + x0 * (y1 - y2) + x1 * y2;
        sn = y0 * x2 - x0 * y2 + (y2 - y0) * px + (x0 - x2) * py;
        tn = x0 * y1 - y0 * x1 + (y0 - y1) * px + (x1 - x0) * py;
        un = a2 - sn - tn;
        if (a2 > 0) in_tri = sn > 0 && tn > 0 && un > 0;
        else if (a2 < 0) in_tri = sn < 0 && tn < 0 && un < 0;
        else in_tri = 0;
        if (in_tri) begin
            d0 = vertex_dist(x0, y0, px, py);
            d1 = vertex_dist(x1, y1, px, py);
            d2 = vertex_dist(x2, y2, px, py);
            p0 = d1 * d2; p1 = d0 * d2; p2 = d0 * d1;
            sum = p0 + p1 + p2;
            w0 = (p0 << WEIGHT_FRAC_BITS) / sum;
            w1 = (p1 << WEIGHT_FRAC_BITS) / sum;
            w2 = (p2 << WEIGHT_FRAC_BITS) / sum;
            r.red = blend(w0, w1, w2, 16);
            r.green = blend(w0, w1, w2, 8);
            r.blue = blend(w0, w1, w2, 0);
            r.hit = 1'b1;
        end else begin
            r.red = col_bg[23:16];
            r.green = col_bg[15:8];
            r.blue = col_bg[7:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_VERTEX_A: vtx_a = val;
            REG_VERTEX_B: vtx_b = val;
            REG_VERTEX_C: vtx_c = val;
            REG_COLOR_A: col_a = val[23:0];
            REG_COLOR_B: col_b = val[23:0];
            REG_COLOR_C: col_c = val[23:0];
            default: col_bg = val[23:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic set_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
    endtask

    task automatic set_colors(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                              logic [23:0] bg);
        write_reg(REG_COLOR_A, {8'd0, a});
        write_reg(REG_COLOR_B, {8'd0, b});
        write_reg(REG_COLOR_C, {8'd0, c});
        write_reg(REG_BACKGROUND, {8'd0, bg});
    endtask

    // pixels mostly near the triangle's bounding box, some anywhere
    task automatic queue_random(int n);
        int xmin, xmax, ymin, ymax;
        logic [11:0] x, y;
        xmin = vtx_a[31:20]; xmax = xmin;
        ymin = vtx_a[15:4]; ymax = ymin;
        if (vtx_b[31:20] < xmin) xmin = vtx_b[31:20];
        if (vtx_c[31:20] < xmin) xmin = vtx_c[31:20];
        if (vtx_b[31:20] > xmax) xmax = vtx_b[31:20];
        if (vtx_c[31:20] > xmax) xmax = vtx_c[31:20];
        if (vtx_b[15:4] < ymin) ymin = vtx_b[15:4];
        if (vtx_c[15:4] < ymin) ymin = vtx_c[15:4];
        if (vtx_b[15:4] > ymax) ymax = vtx_b[15:4];
        if (vtx_c[15:4] > ymax) ymax = vtx_c[15:4];
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                x = 12'($urandom_range(xmax + 1, xmin));
                y = 12'($urandom_range(ymax + 1, ymin));
            end else begin
                x = 12'($urandom);
                y = 12'($urandom);
            end
            pending_pixels.push_back({y, x});
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            // previous item taken (or none), choose the next one
            if (s_tvalid) void'(pending_pixels.pop_front());
            if (gap_left > 0) gap_left--;
            if (pending_pixels.size() != 0 && gap_left == 0 && !hold_sender) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pixels[0];
                if (burst_left == 0) begin
                    burst_left = $urandom_range(30, 1);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict at acceptance, so config at that moment applies
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_pixels.push_back(shade_pixel(s_tdata));
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if ((cycles / 500) % 3 == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(3) != 0);
    end

    // monitor
    always @(posedge aclk) begin
        pixel_t exp_px;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected item %h/%b", m_tdata, m_tuser);
                errors++;
            end else begin
                exp_px = expected_pixels.pop_front();
                if (m_tdata[7:0] !== exp_px.red) begin
                    $error("red exp %0d got %0d", exp_px.red, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== exp_px.green) begin
                    $error("green exp %0d got %0d", exp_px.green, m_tdata[15:8]);
                    errors++;
                end
                if (m_tdata[23:16] !== exp_px.blue) begin
                    $error("blue exp %0d got %0d", exp_px.blue, m_tdata[23:16]);
                    errors++;
                end
                if (m_tuser !== exp_px.hit) begin
                    $error("inside_res exp %0b got %0b", exp_px.hit, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_VERTEX_A;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        hold_sender = 0;
        vtx_a = VERTEX_A_RST; vtx_b = VERTEX_B_RST; vtx_c = VERTEX_C_RST;
        col_a = COLOR_A_RST; col_b = COLOR_B_RST; col_c = COLOR_C_RST;
        col_bg = BACKGROUND_RST;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset triangle, vertices, extremes
        pending_pixels.push_back({12'd0, 12'd0});
        pending_pixels.push_back({12'hFFF, 12'hFFF});
        pending_pixels.push_back({12'd0, 12'hFFF});
        pending_pixels.push_back({12'hFFF, 12'd0});
        pending_pixels.push_back({vtx_a[15:4], vtx_a[31:20]});
        pending_pixels.push_back({vtx_b[15:4], vtx_b[31:20]});
        pending_pixels.push_back({vtx_c[15:4], vtx_c[31:20]});
        pending_pixels.push_back({12'hAAA, 12'h555});
        pending_pixels.push_back({12'h555, 12'hAAA});
        queue_random(6);
        drain();

        // axis-aligned right triangle: hypotenuse and legs fall on pixels
        set_triangle({16'd160, 16'd160}, {16'd1600, 16'd160}, {16'd160, 16'd1600});
        set_colors(24'hFFFFFF, 24'h000000, 24'h80FF01, 24'hFFFFFF);
        for (int i = 10; i <= 100; i += 30) begin
            pending_pixels.push_back({12'd10, i[11:0]});
            pending_pixels.push_back({i[11:0], 12'd10});
            pending_pixels.push_back({12'd110 - i[11:0], i[11:0]});
            pending_pixels.push_back({12'd109 - i[11:0], i[11:0]});
        end
        drain();

        // zero area: collinear points
        set_triangle({16'd16, 16'd16}, {16'd320, 16'd320}, {16'd640, 16'd640});
        pending_pixels.push_back({12'd10, 12'd10});
        pending_pixels.push_back({12'd12, 12'd10});
        queue_random(20);
        drain();

        // full range triangle, clockwise, extreme coordinates
        set_triangle(32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0000);
        set_colors(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        queue_random(150);
        drain();

        // pause until all results are back, then resume
        hold_sender = 1;
        queue_random(50);
        repeat (LATENCY + 20) @(posedge aclk);
        hold_sender = 0;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_triangle($urandom, $urandom, $urandom);
            set_colors(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
            queue_random(100);
            drain();
        end

        // small triangle, counter-clockwise, random fractions
        set_triangle({16'd100, 16'd100}, {16'd100 + 16'($urandom_range(255)), 16'd90},
                     {16'd110, 16'd300});
        queue_random(60);
        drain();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
